### rtl/core/gtk_pkg.sv
// Package for the top-K min pair selector: item types and constants.
// No dependencies.
`default_nettype none
package gtk_pkg;
    localparam int COL_W = 16;
    localparam int SCORE_W = 24;
    localparam int CAP_W = 7;
    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [COL_W-1:0]          col_a;
        logic [COL_W-1:0]          col_b;
        logic signed [SCORE_W-1:0] score;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]          out_col_a;
        logic [COL_W-1:0]          out_col_b;
        logic signed [SCORE_W-1:0] out_score;
        logic                      entry_valid;
        logic                      last;
    } out_item_t;
endpackage
`default_nettype wire

### rtl/core/global_top_k_min_pair_selector_top.sv
// Top level of the top-K min pair selector: slot store, sequencer, one shared comparator.
// Uses gtk_pkg.
//
//  channel  | signals                     | handshake
//  input    | start, busy, in_item        | taken when start && !busy
//  result   | res_strobe, res_item        | one-cycle strobe per item, no stall
//  config   | cap_we, cap_wdata           | written when cap_we high
//
// Offer: the live slots are read one per cycle through a registered read port and
// compared in the following cycle, then a write state follows (cap 0: dropped).
// Drain: one full scan plus one emit state per emitted item; an empty drain still
// emits a single item, marked invalid and last.
// Reset clears used bits and sets capacity to 64; slot data is not reset.
// The result side cannot stall; busy stays high for the whole item.
`default_nettype none
module global_top_k_min_pair_selector_top #(
    parameter int MAX_KEPT = 64,
    parameter int COL_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire gtk_pkg::in_item_t          in_item,
    output logic                            res_strobe,
    output gtk_pkg::out_item_t              res_item,
    input  wire logic                       cap_we,
    input  wire logic [gtk_pkg::CAP_W-1:0]  cap_wdata
);
    localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int DW = (COL_BITS < gtk_pkg::COL_W) ? COL_BITS : gtk_pkg::COL_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_DSCAN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [gtk_pkg::CAP_W-1:0] cap_reg;
    logic [MAX_KEPT-1:0] used_reg, emitted_reg;
    logic [gtk_pkg::COL_W-1:0] mem_a [MAX_KEPT];
    logic [gtk_pkg::COL_W-1:0] mem_b [MAX_KEPT];
    logic signed [gtk_pkg::SCORE_W-1:0] mem_s [MAX_KEPT];

    gtk_pkg::in_item_t item_reg;
    logic [CW-1:0] idx_reg, effcap;
    logic [IW-1:0] best_reg;
    logic best_vld_reg;
    logic [gtk_pkg::COL_W-1:0] ba_reg, bb_reg;
    logic signed [gtk_pkg::SCORE_W-1:0] bs_reg;
    logic best_used_reg;
    logic [CW-1:0] cnt_reg;

    logic [IW-1:0] rd_idx_reg;
    logic rd_vld_reg;
    logic [gtk_pkg::COL_W-1:0] rd_a_reg, rd_b_reg;
    logic signed [gtk_pkg::SCORE_W-1:0] rd_s_reg;

    logic [IW-1:0] ridx;
    logic take;
    logic issue;
    logic cmp_en;
    logic scan_done;
    logic is_last;

    assign effcap = ({{(32-gtk_pkg::CAP_W){1'b0}}, cap_reg} > MAX_KEPT)
        ? CW'(MAX_KEPT) : CW'(cap_reg);
    assign ridx = idx_reg[IW-1:0];
    assign busy = (state_reg != S_IDLE);
    assign issue = (state_reg == S_SCAN || state_reg == S_DSCAN) && (idx_reg < effcap);
    assign cmp_en = (state_reg == S_SCAN || state_reg == S_DSCAN) && rd_vld_reg;
    // last compare of the pass is the one on slot effcap-1
    assign scan_done = (effcap == '0)
        || (rd_vld_reg && (CW'(rd_idx_reg) + CW'(1) == effcap));
    // cnt_reg holds the pairs still unemitted in this pass, best included
    assign is_last = !best_vld_reg || (cnt_reg == CW'(1));

    // shared comparator: registered read data vs current best
    always_comb
    begin
        take = 1'b0;
        if (state_reg == S_SCAN)
        begin
            // strictly greater score wins; unused counts as +inf
            if (!best_vld_reg)
                take = 1'b1;
            else if (best_used_reg)
                take = !used_reg[rd_idx_reg] || (rd_s_reg > bs_reg);
        end
        else
        begin
            if (used_reg[rd_idx_reg] && !emitted_reg[rd_idx_reg])
                take = !best_vld_reg || (rd_a_reg < ba_reg)
                    || (rd_a_reg == ba_reg && rd_b_reg < bb_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    if (in_item.kind == gtk_pkg::KIND_DRAIN)
                        state_next = S_DSCAN;
                    else if (effcap != '0)
                        state_next = S_SCAN;
                end
            S_SCAN:
                if (scan_done)
                    state_next = S_WRITE;
            S_WRITE:
                state_next = S_IDLE;
            S_DSCAN:
                if (scan_done)
                    state_next = S_EMIT;
            S_EMIT:
                if (is_last)
                    state_next = S_IDLE;
                else
                    state_next = S_DSCAN;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cap_reg <= gtk_pkg::CAP_W'(64);
            used_reg <= '0;
            emitted_reg <= '0;
            idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            best_vld_reg <= 1'b0;
            cnt_reg <= '0;
            res_strobe <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_strobe <= 1'b0;
            if (cap_we)
                cap_reg <= cap_wdata;
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    rd_vld_reg <= 1'b0;
                    best_vld_reg <= 1'b0;
                    emitted_reg <= '0;
                    cnt_reg <= '0;
                end
                S_SCAN, S_DSCAN:
                begin
                    if (issue)
                        idx_reg <= idx_reg + CW'(1);
                    rd_vld_reg <= issue;
                    if (cmp_en && take)
                        best_vld_reg <= 1'b1;
                    if (cmp_en && state_reg == S_DSCAN && used_reg[rd_idx_reg]
                        && !emitted_reg[rd_idx_reg])
                        cnt_reg <= cnt_reg + CW'(1);
                end
                S_WRITE:
                begin
                    if (!best_used_reg || item_reg.score < bs_reg)
                        used_reg[best_reg] <= 1'b1;
                end
                S_EMIT:
                begin
                    res_strobe <= 1'b1;
                    if (best_vld_reg)
                        emitted_reg[best_reg] <= 1'b1;
                    if (is_last)
                        used_reg <= '0;
                    best_vld_reg <= 1'b0;
                    idx_reg <= '0;
                    rd_vld_reg <= 1'b0;
                    cnt_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload and store
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            item_reg <= in_item;
        if (issue)
        begin
            rd_a_reg <= mem_a[ridx];
            rd_b_reg <= mem_b[ridx];
            rd_s_reg <= mem_s[ridx];
            rd_idx_reg <= ridx;
        end
        if (cmp_en && take)
        begin
            best_reg <= rd_idx_reg;
            ba_reg <= rd_a_reg;
            bb_reg <= rd_b_reg;
            bs_reg <= rd_s_reg;
            best_used_reg <= used_reg[rd_idx_reg];
        end
        if (state_reg == S_WRITE && (!best_used_reg || item_reg.score < bs_reg))
        begin
            mem_a[best_reg] <= gtk_pkg::COL_W'(item_reg.col_a[DW-1:0]);
            mem_b[best_reg] <= gtk_pkg::COL_W'(item_reg.col_b[DW-1:0]);
            mem_s[best_reg] <= item_reg.score;
        end
        if (state_reg == S_EMIT)
        begin
            res_item.out_col_a <= best_vld_reg ? ba_reg : '0;
            res_item.out_col_b <= best_vld_reg ? bb_reg : '0;
            res_item.out_score <= best_vld_reg ? bs_reg : '0;
            res_item.entry_valid <= best_vld_reg;
            res_item.last <= is_last;
        end
    end

    // the drain ends exactly with its last item
    a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe |-> (busy == !res_item.last));
    a_invalid_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_strobe && !res_item.entry_valid) |-> res_item.last);
    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg <= S_EMIT);
    a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_item.kind == gtk_pkg::KIND_DRAIN) |=> busy);
endmodule
`default_nettype wire
